/* hdl/lrukv_pkg.sv */
// Shared types, status codes and the sequencer microcode for the LRU key/value cache.
package lrukv_pkg;

  localparam int KEY_W    = 16;
  localparam int VAL_W    = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int CFG_W    = 5;

  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FILLED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_ACCESS = 1'b1;

  typedef enum logic [1:0] {
    P_IDLE,
    P_SCAN,
    P_DRAIN,
    P_COMMIT
  } step_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_LAST,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic  accept_en;
    logic  rd_en;
    logic  commit_en;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ctl_word_t;

  // The whole program: one control word per step.
  function automatic ctl_word_t ucode_rom(input step_t pc);
    ctl_word_t w;
    w = '{accept_en: 1'b0, rd_en: 1'b0, commit_en: 1'b0, cond: COND_ALWAYS,
          tgt_true: P_IDLE, tgt_false: P_IDLE};
    case (pc)
      P_IDLE: begin
        w.accept_en = 1'b1;
        w.cond      = COND_ACCEPT;
        w.tgt_true  = P_SCAN;
        w.tgt_false = P_IDLE;
      end
      P_SCAN: begin
        w.rd_en     = 1'b1;
        w.cond      = COND_LAST;
        w.tgt_true  = P_DRAIN;
        w.tgt_false = P_SCAN;
      end
      P_DRAIN: begin
        w.cond      = COND_ALWAYS;
        w.tgt_true  = P_COMMIT;
        w.tgt_false = P_COMMIT;
      end
      P_COMMIT: begin
        w.commit_en = 1'b1;
        w.cond      = COND_OUT_FREE;
        w.tgt_true  = P_IDLE;
        w.tgt_false = P_COMMIT;
      end
      default: begin
        w.cond      = COND_ALWAYS;
        w.tgt_true  = P_IDLE;
        w.tgt_false = P_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* hdl/lru_key_value_cache.sv */
// A transaction is accepted in P_IDLE, scans the N active slots in P_SCAN, passes P_DRAIN
// and loads the result register in P_COMMIT, where a stalled output holds it. The next one
// is taken only back in P_IDLE; the slot scan through the memory's single read port sets the pace.
// Reset (rst, synchronous, active high) clears all valid bits and recency ranks and sets
// slots_in_use to 16; no clearing pass is needed, so a transaction is taken the cycle after.
// Key and value storage holds no reset and is only read behind a valid bit.
module lru_key_value_cache #(
  parameter int SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel (slots_in_use).
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrukv_pkg::CFG_W-1:0]     cfg_data,
  // Request channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [lrukv_pkg::KEY_W-1:0]     key,
  input  logic [lrukv_pkg::VAL_W-1:0]     value,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lrukv_pkg::STATUS_W-1:0]  status,
  output logic [lrukv_pkg::VAL_W-1:0]     read_value,
  output logic [lrukv_pkg::KEY_W-1:0]     evicted_key,
  output logic [lrukv_pkg::SLOT_W-1:0]    slot_index
);
  import lrukv_pkg::*;

  localparam int IW = $clog2(SLOTS);  // slot index width
  localparam int RW = $clog2(SLOTS);  // recency rank width; ranks of valid slots are 0..v-1

  // ---------------------------------------------------------------------------
  // Configuration. The port is always ready; writes must only arrive while idle (the block does not enforce it).
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] slots_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CFG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      slots_in_use <= cfg_data;
    end
  end

  // Last active slot index: the register clamped to 1..SLOTS, minus one.
  logic [IW-1:0] last_slot_next;

  always_comb begin
    if (slots_in_use == '0) begin
      last_slot_next = '0;
    end else if (int'(slots_in_use) > SLOTS) begin
      last_slot_next = IW'(SLOTS - 1);
    end else begin
      last_slot_next = IW'(slots_in_use - CFG_W'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Microcoded sequencer. The step counter pc indexes the control ROM; each
  // word carries its strobes, a jump condition and both jump targets.
  // ---------------------------------------------------------------------------
  step_t     pc;
  step_t     pc_next;
  ctl_word_t ctl;
  logic      cond_true;
  logic      in_accept;
  logic      out_free;
  logic      commit;
  logic [IW-1:0] idx;
  logic [IW-1:0] last_slot;

  assign ctl       = ucode_rom(pc);
  assign in_stall  = !ctl.accept_en;
  assign in_accept = in_valid && ctl.accept_en;
  assign out_free  = !out_valid || !out_stall;
  assign commit    = ctl.commit_en && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    case (ctl.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_ACCEPT:   cond_true = in_accept;
      COND_LAST:     cond_true = (idx == last_slot);
      COND_OUT_FREE: cond_true = out_free;
      default:       cond_true = 1'b1;
    endcase
    pc_next = cond_true ? ctl.tgt_true : ctl.tgt_false;
  end

  // Latched request and scan address counter.
  logic             req_mode;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_value;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_mode  <= mode;
      req_key   <= key;
      req_value <= value;
      last_slot <= last_slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (in_accept) begin
      idx <= '0;
    end else if (ctl.rd_en && idx != last_slot) begin
      idx <= idx + IW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Key/value memory: one write port, one registered read port used by the scan.
  // ---------------------------------------------------------------------------
  logic [KEY_W+VAL_W-1:0] kv_mem [SLOTS];
  logic [KEY_W+VAL_W-1:0] kv_q;
  logic                   mem_wr;
  logic [IW-1:0]          wr_slot;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      kv_mem[wr_slot] <= {req_key, req_value};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      kv_q <= kv_mem[idx];
    end
  end

  // Valid bits and recency ranks live in flip-flops, one cell per slot.
  logic          slot_valid [SLOTS];
  logic [RW-1:0] rank       [SLOTS];

  // ---------------------------------------------------------------------------
  // Scan compare stage: one slot per cycle, in the cycle after its read address.
  // It records the first matching valid slot, the first empty slot and the
  // oldest slot (first one with the largest rank).
  // ---------------------------------------------------------------------------
  logic          cmp_vld;
  logic [IW-1:0] cmp_idx;
  logic          cmp_valid_bit;
  logic [RW-1:0] cmp_rank;

  logic             hit_found;
  logic [IW-1:0]    hit_idx;
  logic [VAL_W-1:0] hit_val;
  logic [RW-1:0]    hit_rank;
  logic             emp_found;
  logic [IW-1:0]    emp_idx;
  logic [IW-1:0]    vic_idx;
  logic [RW-1:0]    vic_rank;
  logic [KEY_W-1:0] vic_key;

  assign cmp_valid_bit = slot_valid[cmp_idx];
  assign cmp_rank      = rank[cmp_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      cmp_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found <= 1'b0;
      emp_found <= 1'b0;
    end else if (in_accept) begin
      hit_found <= 1'b0;
      emp_found <= 1'b0;
    end else if (cmp_vld) begin
      if (!hit_found && cmp_valid_bit && kv_q[KEY_W+VAL_W-1:VAL_W] == req_key) begin
        hit_found <= 1'b1;
      end
      if (!emp_found && !cmp_valid_bit) begin
        emp_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld) begin
      if (!hit_found && cmp_valid_bit && kv_q[KEY_W+VAL_W-1:VAL_W] == req_key) begin
        hit_idx  <= cmp_idx;
        hit_val  <= kv_q[VAL_W-1:0];
        hit_rank <= cmp_rank;
      end
      if (!emp_found && !cmp_valid_bit) begin
        emp_idx <= cmp_idx;
      end
      if (cmp_idx == '0 || cmp_rank > vic_rank) begin
        vic_idx  <= cmp_idx;
        vic_rank <= cmp_rank;
        vic_key  <= kv_q[KEY_W+VAL_W-1:VAL_W];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Commit: choose the case, write the slot, update recency and load the result.
  // ---------------------------------------------------------------------------
  logic [STATUS_W-1:0] res_status;
  logic [VAL_W-1:0]    res_read;
  logic [KEY_W-1:0]    res_evict;
  logic                do_promote;
  logic                do_enter;
  logic [RW-1:0]       promote_rank;

  always_comb begin
    res_status   = ST_MISS;
    res_read     = '0;
    res_evict    = '0;
    wr_slot      = hit_idx;
    promote_rank = hit_rank;
    do_promote   = 1'b0;
    do_enter     = 1'b0;
    mem_wr       = 1'b0;
    if (req_mode == MODE_ACCESS) begin
      if (hit_found) begin
        res_status = ST_HIT;
        res_read   = hit_val;
        do_promote = commit;
      end
    end else if (hit_found) begin
      res_status = ST_UPDATED;
      do_promote = commit;
      mem_wr     = commit;
    end else if (emp_found) begin
      res_status = ST_FILLED;
      wr_slot    = emp_idx;
      do_enter   = commit;
      mem_wr     = commit;
    end else begin
      // Every active slot is valid: the oldest one is replaced.
      res_status   = ST_REPLACED;
      res_evict    = vic_key;
      wr_slot      = vic_idx;
      promote_rank = vic_rank;
      do_promote   = commit;
      mem_wr       = commit;
    end
  end

  // Each slot updates its own rank: on a promote the slots newer than the
  // touched one age by one, on an enter every valid slot ages by one.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        rank[i]       <= '0;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if ((do_promote || do_enter) && wr_slot == IW'(i)) begin
          rank[i]       <= '0;
          slot_valid[i] <= 1'b1;
        end else if (do_enter && slot_valid[i]) begin
          rank[i] <= rank[i] + RW'(1);
        end else if (do_promote && slot_valid[i] && rank[i] < promote_rank) begin
          rank[i] <= rank[i] + RW'(1);
        end
      end
    end
  end

  // Output register: holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status      <= res_status;
      read_value  <= res_read;
      evicted_key <= res_evict;
      slot_index  <= (res_status == ST_MISS) ? '0 : SLOT_W'(wr_slot);
    end
  end

endmodule

/* hdl/lrukv_checker.sv */
// Port-level checker for the LRU key/value cache and its bind to the top level.
module lrukv_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [lrukv_pkg::STATUS_W-1:0]  status,
  input logic [lrukv_pkg::VAL_W-1:0]     read_value,
  input logic [lrukv_pkg::KEY_W-1:0]     evicted_key,
  input logic [lrukv_pkg::SLOT_W-1:0]    slot_index
);
  import lrukv_pkg::*;

  // A stalled result stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_value)
      && $stable(evicted_key) && $stable(slot_index))
    else $error("result changed while stalled");

  // A miss touches no slot and returns nothing.
  a_miss_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_MISS |-> read_value == '0 && evicted_key == '0
      && slot_index == '0)
    else $error("miss carries data");

  // Only a replacement reports an evicted key.
  a_evict_only_replace: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_REPLACED |-> evicted_key == '0)
    else $error("evicted key without replacement");

  // Only an access hit returns a stored value.
  a_read_only_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_HIT |-> read_value == '0)
    else $error("read value without access hit");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_UPDATED || status == ST_FILLED || status == ST_REPLACED
      || status == ST_HIT || status == ST_MISS)
    else $error("undefined status code");

endmodule

bind lru_key_value_cache lrukv_checker u_lrukv_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .read_value  (read_value),
  .evicted_key (evicted_key),
  .slot_index  (slot_index)
);

/* test/lru_key_value_cache_tb.sv */
// Self-checking testbench for the LRU key/value cache, with a cycle-free predictor and scoreboard.
`timescale 1ns / 100ps

module lru_key_value_cache_tb;
  import lrukv_pkg::*;

  localparam int SLOTS = 16;
  // No transaction of any kind for this many cycles means the block is hung. The limit lies
  // far above the longest quiet spell of a correct run (scan, longest stall, longest gap).
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 140;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    read_value;
    logic [KEY_W-1:0]    evicted_key;
    logic [SLOT_W-1:0]   slot_index;
  } cache_result_t;

  class cache_scoreboard;
    logic [CFG_W-1:0]  slot_count_reg;
    bit                entry_valid [SLOTS];
    logic [KEY_W-1:0]  entry_key   [SLOTS];
    logic [VAL_W-1:0]  entry_value [SLOTS];
    logic [SLOT_W-1:0] entry_age   [SLOTS];
    cache_result_t     expected_q[$];
    int                errors;
    int                requests;
    int                results;
    int                status_seen [5];
    int                slot_writes;

    function new();
      slot_count_reg = 5'd16;
      for (int i = 0; i < SLOTS; i++) begin
        entry_valid[i] = 1'b0;
        entry_key[i]   = '0;
        entry_value[i] = '0;
        entry_age[i]   = '0;
      end
      errors      = 0;
      requests    = 0;
      results     = 0;
      slot_writes = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_slot_count(logic [CFG_W-1:0] data);
      slot_count_reg = data;
      slot_writes++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Slots that were newer than s age by one; s becomes the newest.
    function void make_newest(int s);
      for (int i = 0; i < SLOTS; i++)
        if (i != s && entry_valid[i] && entry_age[i] < entry_age[s])
          entry_age[i]++;
      entry_age[s] = '0;
    endfunction

    function void note_request(logic m, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      cache_result_t r;
      int n;
      int hit;
      int empty;
      int victim;
      n = (slot_count_reg < 1) ? 1 : ((slot_count_reg > SLOTS) ? SLOTS : int'(slot_count_reg));
      hit = -1;
      empty = -1;
      for (int i = 0; i < n; i++)
        if (hit < 0 && entry_valid[i] && entry_key[i] == k) hit = i;
      r = '0;
      if (m == MODE_ACCESS) begin
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.status     = ST_HIT;
          r.slot_index = SLOT_W'(hit);
          r.read_value = entry_value[hit];
          make_newest(hit);
        end
      end else if (hit >= 0) begin
        r.status         = ST_UPDATED;
        r.slot_index     = SLOT_W'(hit);
        entry_value[hit] = v;
        make_newest(hit);
      end else begin
        for (int i = 0; i < n; i++)
          if (empty < 0 && !entry_valid[i]) empty = i;
        if (empty >= 0) begin
          // A new entry: every valid slot ages, the filled one is newest.
          r.status           = ST_FILLED;
          r.slot_index       = SLOT_W'(empty);
          entry_key[empty]   = k;
          entry_value[empty] = v;
          for (int i = 0; i < SLOTS; i++)
            if (entry_valid[i]) entry_age[i]++;
          entry_valid[empty] = 1'b1;
          entry_age[empty]   = '0;
        end else begin
          victim = 0;
          for (int i = 1; i < n; i++)
            if (entry_age[i] > entry_age[victim]) victim = i;
          r.status            = ST_REPLACED;
          r.slot_index        = SLOT_W'(victim);
          r.evicted_key       = entry_key[victim];
          entry_key[victim]   = k;
          entry_value[victim] = v;
          make_newest(victim);
        end
      end
      expected_q.push_back(r);
      requests++;
    endfunction

    function void check_result(cache_result_t got);
      cache_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no transaction pending: status %0d value %h evicted %h slot %0d",
                 $time, got.status, got.read_value, got.evicted_key, got.slot_index);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      results++;
      if (want.status <= ST_MISS) status_seen[want.status]++;
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value mismatch: expected %h, actual %h",
                 $time, want.read_value, got.read_value);
        errors++;
      end
      if (got.evicted_key !== want.evicted_key) begin
        $display("%0t: evicted_key mismatch: expected %h, actual %h",
                 $time, want.evicted_key, got.evicted_key);
        errors++;
      end
      if (got.slot_index !== want.slot_index) begin
        $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                 $time, want.slot_index, got.slot_index);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                mode = MODE_INSERT;
  logic [KEY_W-1:0]    key = '0;
  logic [VAL_W-1:0]    value = '0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    read_value;
  logic [KEY_W-1:0]    evicted_key;
  logic [SLOT_W-1:0]   slot_index;

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_run = 0;
  int settings_used = 0;

  cache_scoreboard sb;

  lru_key_value_cache #(.SLOTS(SLOTS)) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_value  (read_value),
    .evicted_key (evicted_key),
    .slot_index  (slot_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, but stall_run caps each run of stalls in a row, so
  // the worst-case wait per result stays bounded for the watchdog.
  always @(posedge clk) begin
    if (recv_stall_pct > 0 && stall_run < 16 && $urandom_range(99) < recv_stall_pct) begin
      out_stall <= 1'b1;
      stall_run = stall_run + 1;
    end else begin
      out_stall <= 1'b0;
      stall_run = 0;
    end
  end

  // All inputs change only by nonblocking assignment at the rising edge, so the values read
  // here are the ones the block saw at this edge. A result at this edge always belongs to an
  // earlier transaction, since a request passes the whole scan before its result is committed.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result(cache_result_t'{status, read_value, evicted_key, slot_index});
      if (cfg_valid && cfg_ready)
        sb.write_slot_count(cfg_data);
      if (in_valid && !in_stall)
        sb.note_request(mode, key, value);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Pressure mixes: 0 none, 1 sender gaps, 2 receiver stalls, 3 both.
  task automatic set_pressure(int mix);
    case (mix)
      1: begin
        send_idle_pct  = 60;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 60;
      end
      3: begin
        send_idle_pct  = 38;
        recv_stall_pct = 38;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Called right after a rising edge. The payload holds until the block takes it.
  task automatic send_request(logic m, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && gap < 20 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      gap++;
    end
    in_valid <= 1'b1;
    mode     <= m;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and let every outstanding result come back, so the block is idle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slot_count(logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Random traffic over a small key pool, a little larger than the active slot count,
  // so that hits, updates, fills and LRU replacements all happen often. A few keys are
  // drawn from the whole range to mix in misses and fresh inserts.
  task automatic random_phase(logic [CFG_W-1:0] count, int mix, int items);
    logic [KEY_W-1:0] pool[$];
    int active;
    logic [KEY_W-1:0] k;
    logic m;
    drain();
    write_slot_count(count);
    set_pressure(mix);
    active = (count < 1) ? 1 : ((count > SLOTS) ? SLOTS : int'(count));
    repeat (active + $urandom_range(1, 8)) pool.push_back(KEY_W'($urandom_range(0, 65535)));
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 88)
        k = pool[$urandom_range(pool.size() - 1)];
      else
        k = KEY_W'($urandom);
      m = ($urandom_range(99) < 45) ? MODE_INSERT : MODE_ACCESS;
      send_request(m, k, VAL_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_count [PHASES];
    sb = new();
    phase_count = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd16, 5'd8, 5'd12, 5'd3, 5'd0, 5'd0};
    phase_count[10] = CFG_W'($urandom_range(0, 31));
    phase_count[11] = CFG_W'($urandom_range(0, 31));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two slots: fill both, hit, miss, update, then replace the older entry twice.
    // Key and value extremes appear here.
    write_slot_count(5'd2);
    send_request(MODE_INSERT, 16'h0000, 16'h0000);
    send_request(MODE_INSERT, 16'hFFFF, 16'hFFFF);
    send_request(MODE_ACCESS, 16'h0000, 16'hFFFF);
    send_request(MODE_ACCESS, 16'hFFFF, 16'h0000);
    send_request(MODE_ACCESS, 16'h1234, 16'h0000);
    send_request(MODE_INSERT, 16'h0000, 16'hA5A5);
    send_request(MODE_INSERT, 16'h8001, 16'h7FFF);
    send_request(MODE_ACCESS, 16'hFFFF, 16'h0000);
    send_request(MODE_ACCESS, 16'h8001, 16'h0000);
    send_request(MODE_INSERT, 16'h0002, 16'hFFFF);
    send_request(MODE_ACCESS, 16'h0000, 16'h0000);

    // Shrink to one slot: the second slot keeps its key, and the insert of that same key
    // replaces slot 0, which leaves two valid slots holding one key.
    drain();
    write_slot_count(5'd1);
    send_request(MODE_INSERT, 16'h8001, 16'h0001);
    send_request(MODE_ACCESS, 16'h8001, 16'h0000);

    // Growing again exposes the duplicate; the lower slot must match.
    drain();
    write_slot_count(5'd2);
    send_request(MODE_ACCESS, 16'h8001, 16'h0000);
    send_request(MODE_INSERT, 16'h8001, 16'h5555);

    // A count of zero behaves as one slot.
    drain();
    write_slot_count(5'd0);
    send_request(MODE_INSERT, 16'h3C3C, 16'hC3C3);

    // A count above the slot total behaves as all sixteen.
    drain();
    write_slot_count(5'd31);
    send_request(MODE_INSERT, 16'h4242, 16'h2424);
    send_request(MODE_ACCESS, 16'h3C3C, 16'h0000);
    send_request(MODE_ACCESS, 16'h8001, 16'h0000);

    for (int p = 0; p < PHASES; p++)
      random_phase(phase_count[p], p % 4, ITEMS_PER_PHASE);

    drain();
    repeat (40) @(posedge clk);

    $display("Ran %0d requests and checked %0d results over %0d slot-count writes and four",
             sb.requests, sb.results, settings_used);
    $display("pressure mixes: %0d updates, %0d fills, %0d replacements, %0d hits, %0d misses.",
             sb.status_seen[ST_UPDATED], sb.status_seen[ST_FILLED],
             sb.status_seen[ST_REPLACED], sb.status_seen[ST_HIT], sb.status_seen[ST_MISS]);
    if (sb.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
